FILE: rtl/core/tsbf_pkg.sv
// Shared types and codes for the two-stage batch FIFO.
package tsbf_pkg;

  localparam int PAYLOAD_W = 32;
  localparam int SEQ_W = 48;
  localparam int TIME_W = 64;
  localparam int LIMIT_W = 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [1:0] {
    RES_INSERTED = 2'd0,
    RES_REJECTED = 2'd1,
    RES_RETURNED = 2'd2,
    RES_EMPTY    = 2'd3
  } result_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     sequence_num;
    logic [TIME_W-1:0]    stamp;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_item;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
    logic has_item;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/tsbf_ctrl.sv
// Controller state machine that sequences capture, execution and ring read.
module tsbf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsbf_pkg::dp_status_t st,
  output tsbf_pkg::ctrl_cmd_t  cmd
);
  import tsbf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.out_free) begin
          cmd.exec = 1'b1;
          if (st.is_get && st.has_item) begin
            state_next = S_FETCH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        cmd.load_item = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/tsbf_datapath.sv
// Datapath with the entry ring, batch counters, sequence counters and result register.
module tsbf_datapath #(
  parameter int RING_DEPTH = 64,
  parameter int CNT_W = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tsbf_pkg::ctrl_cmd_t                 cmd,
  output tsbf_pkg::dp_status_t                st,
  input  logic                                cfg_we,
  input  logic [tsbf_pkg::LIMIT_W-1:0]        cfg_wdata,
  input  logic                                opcode,
  input  logic [tsbf_pkg::PAYLOAD_W-1:0]      payload,
  input  logic [tsbf_pkg::TIME_W-1:0]         now_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic [tsbf_pkg::PAYLOAD_W-1:0]      item_payload,
  output logic [tsbf_pkg::SEQ_W-1:0]          item_sequence,
  output logic [tsbf_pkg::TIME_W-1:0]         item_time,
  output logic [CNT_W-1:0]                    pending_count,
  output logic [tsbf_pkg::SEQ_W-1:0]          consumed_total
);
  import tsbf_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W = AW + 2;
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  entry_t mem [RING_DEPTH];
  entry_t rd_data;

  logic [LIMIT_W-1:0]   batch_limit;
  logic                 op_q;
  logic [PAYLOAD_W-1:0] payload_q;
  logic [TIME_W-1:0]    time_q;

  logic [AW-1:0]        read_pointer;
  logic [CNT_W-1:0]     consumer_count;
  logic [CNT_W-1:0]     producer_count;
  logic [SEQ_W-1:0]     sequence_counter;
  logic [SEQ_W-1:0]     consumed_counter;

  logic [CNT_W-1:0]     total;
  logic                 reject;
  logic [SUM_W-1:0]     wr_sum;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rp_inc;
  logic [CNT_W-1:0]     cons_eff;
  logic [CNT_W-1:0]     prod_eff;
  logic                 do_write;
  logic                 do_read;

  always_comb begin
    total = consumer_count + producer_count;
    reject = (payload_q == '0) ||
             ((batch_limit != '0) && (CMP_W'(producer_count) >= CMP_W'(batch_limit))) ||
             (total == CNT_W'(RING_DEPTH));
    wr_sum = SUM_W'(read_pointer) + SUM_W'(total);
    if (wr_sum >= SUM_W'(RING_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(RING_DEPTH);
    end
    wr_addr = wr_sum[AW-1:0];
    rp_inc = (read_pointer == AW'(RING_DEPTH - 1)) ? '0 : read_pointer + 1'b1;
    cons_eff = (consumer_count == '0) ? producer_count : consumer_count;
    prod_eff = (consumer_count == '0) ? '0 : producer_count;
    do_write = cmd.exec && (op_q == OP_INSERT) && !reject;
    do_read = cmd.exec && (op_q == OP_GET) && (cons_eff != '0);
    st.is_get = (op_q == OP_GET);
    st.has_item = (total != '0);
    st.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= '{payload: payload_q, sequence_num: sequence_counter + 1'b1,
                        stamp: time_q};
    end
    if (do_read) begin
      rd_data <= mem[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= opcode;
      payload_q <= payload;
      time_q <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_limit <= '0;
      read_pointer <= '0;
      consumer_count <= '0;
      producer_count <= '0;
      sequence_counter <= '0;
      consumed_counter <= '0;
    end else begin
      if (cfg_we) begin
        batch_limit <= cfg_wdata;
      end
      if (do_write) begin
        sequence_counter <= sequence_counter + 1'b1;
        producer_count <= producer_count + 1'b1;
      end
      if (do_read) begin
        read_pointer <= rp_inc;
        consumer_count <= cons_eff - 1'b1;
        producer_count <= prod_eff;
        consumed_counter <= consumed_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.exec && !do_read) || cmd.load_item) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      status <= RES_RETURNED;
      item_payload <= rd_data.payload;
      item_sequence <= rd_data.sequence_num;
      item_time <= rd_data.stamp;
      pending_count <= consumer_count;
      consumed_total <= consumed_counter;
    end else if (cmd.exec && !do_read) begin
      item_payload <= '0;
      item_sequence <= '0;
      item_time <= '0;
      pending_count <= '0;
      consumed_total <= '0;
      if (op_q == OP_GET) begin
        status <= RES_EMPTY;
      end else if (reject) begin
        status <= RES_REJECTED;
      end else begin
        status <= RES_INSERTED;
      end
    end
  end

endmodule

FILE: rtl/core/two_stage_batch_fifo.sv
// Top level of the two-stage batch FIFO: controller and datapath.
//
//   Channel  Handshake                Payload
//   in       in_valid / in_ready      opcode, payload, now_time
//   out      out_valid / out_ready    status, item_payload, item_sequence, item_time,
//                                     pending_count, consumed_total
//   cfg      cfg_we (no wait)         cfg_wdata (producer batch limit)
//
// An insert or an empty get is captured, then executed, and its result registered;
// a get that returns an entry adds the registered ring read before its result loads.
// One item is in flight at a time; the result register lets the next item be
// taken while a result still waits. A stalled output holds execution of the
// next item until the result register frees. Reset is synchronous and clears
// all counters; ring contents are not cleared.
module two_stage_batch_fifo #(
  parameter int RING_DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [tsbf_pkg::LIMIT_W-1:0]                 cfg_wdata,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic                                         opcode,
  input  logic [tsbf_pkg::PAYLOAD_W-1:0]               payload,
  input  logic [tsbf_pkg::TIME_W-1:0]                  now_time,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [1:0]                                   status,
  output logic [tsbf_pkg::PAYLOAD_W-1:0]               item_payload,
  output logic [tsbf_pkg::SEQ_W-1:0]                   item_sequence,
  output logic [tsbf_pkg::TIME_W-1:0]                  item_time,
  output logic [$clog2(RING_DEPTH+1)-1:0]              pending_count,
  output logic [tsbf_pkg::SEQ_W-1:0]                   consumed_total
);
  import tsbf_pkg::*;

  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  tsbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tsbf_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .CNT_W      (CNT_W)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .opcode         (opcode),
    .payload        (payload),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .item_payload   (item_payload),
    .item_sequence  (item_sequence),
    .item_time      (item_time),
    .pending_count  (pending_count),
    .consumed_total (consumed_total)
  );

endmodule
